// ===== design/lgge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid engine package
// Grid geometry, command codes, row type and the row update function shared
// by the channel interfaces and the engine core.
// ----------------------------------------------------------------------------
package lgge_pkg;

   // Grid geometry.
   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 32;

   // Field widths of the command and result beats.
   localparam int CMD_W = 3;
   localparam int COL_W = 6;
   localparam int ROW_W = 5;
   localparam int GEN_W = 32;

   // Index widths that follow from the grid geometry.
   localparam int COL_IDX_W = $clog2(GRID_WIDTH);
   localparam int ROW_IDX_W = $clog2(GRID_HEIGHT);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;

   typedef logic [GRID_WIDTH-1:0] row_type;

   // Applies B3/S23 to one row, given the rows above and below it. Columns
   // wrap at both edges.
   function automatic row_type life_row(input row_type above, input row_type cur,
                                        input row_type below);
      row_type    nxt;
      int         lft;
      int         rgt;
      logic [3:0] cnt;
      nxt = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         lft = (c == 0) ? GRID_WIDTH - 1 : c - 1;
         rgt = (c == GRID_WIDTH - 1) ? 0 : c + 1;
         cnt = 4'(above[lft]) + 4'(above[c]) + 4'(above[rgt]) +
               4'(cur[lft]) + 4'(cur[rgt]) +
               4'(below[lft]) + 4'(below[c]) + 4'(below[rgt]);
         nxt[c] = cur[c] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
      end
      return nxt;
   endfunction

endpackage

// ===== design/lgge_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid engine command channel
// Valid/ready channel that carries one command beat: opcode, cell address
// and the value to write.
// ----------------------------------------------------------------------------
interface lgge_req_if;
   logic                        valid;
   logic                        ready;
   logic [lgge_pkg::CMD_W-1:0]  command;
   logic [lgge_pkg::COL_W-1:0]  col;
   logic [lgge_pkg::ROW_W-1:0]  row;
   logic                        cell_in;

   modport source (output valid, output command, output col, output row,
                   output cell_in, input ready);
   modport sink   (input valid, input command, input col, input row,
                   input cell_in, output ready);
endinterface

// ===== design/lgge_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid engine result channel
// Valid/ready channel that carries one result beat: the addressed cell and
// the generation count.
// ----------------------------------------------------------------------------
interface lgge_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        cell_out;
   logic [lgge_pkg::GEN_W-1:0]  generation;

   modport source (output valid, output cell_out, output generation, input ready);
   modport sink   (input valid, input cell_out, input generation, output ready);
endinterface

// ===== design/life_grid_generation_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine core
// Toroidal Conway B3/S23 grid held in a row-wide synchronous memory, with
// single-cell edit and read commands and a whole-grid generation step.
// ----------------------------------------------------------------------------
// The grid lives in one synchronous memory of GRID_HEIGHT rows, each row one
// word of GRID_WIDTH cells, plus one valid flag per row so that reset and the
// clear command take effect at once (a row that is not valid reads as dead).
// The engine works on one command at a time. Clear and undefined commands
// go straight to the result; write, toggle and read do a row read, modify
// and write back, then the result; a generation step streams one row per
// cycle out of the memory read port: the last and first rows are fetched
// first for the wrap, and each new row is written back through the write
// port while the next one is read. A finished result sits in an output
// register, so the next command is accepted while it waits.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_core (
   input  logic        clock,
   input  logic        reset,
   lgge_req_if.sink    req_bus,
   lgge_rsp_if.source  rsp_bus
);

   localparam int CNT_W = $clog2(lgge_pkg::GRID_HEIGHT + 1);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CELL   = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_LAST   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // Grid memory and its registered read port.
   lgge_pkg::row_type mem [lgge_pkg::GRID_HEIGHT];
   lgge_pkg::row_type rd_data_ff;
   logic              rd_vld_ff;

   logic                            mem_rd_en;
   logic [lgge_pkg::ROW_IDX_W-1:0]  mem_rd_addr;
   logic                            mem_wr_en;
   logic [lgge_pkg::ROW_IDX_W-1:0]  mem_wr_addr;
   lgge_pkg::row_type               mem_wr_data;
   lgge_pkg::row_type               rd_row;

   // Control state.
   logic [2:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                step_cnt_ff, step_cnt_in;
   logic [lgge_pkg::GRID_HEIGHT-1:0] row_valid_ff, row_valid_in;
   logic [lgge_pkg::GEN_W-1:0]      gen_ff, gen_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [lgge_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [lgge_pkg::COL_W-1:0]      col_ff, col_in;
   logic [lgge_pkg::ROW_W-1:0]      row_ff, row_in;
   logic                            cell_in_ff, cell_in_in;
   lgge_pkg::row_type               above_ff, above_in;
   lgge_pkg::row_type               cur_ff, cur_in;
   lgge_pkg::row_type               top_ff, top_in;
   logic                            pend_cell_ff, pend_cell_in;
   logic                            rsp_cell_ff, rsp_cell_in;
   logic [lgge_pkg::GEN_W-1:0]      rsp_gen_ff, rsp_gen_in;

   logic                            req_take;
   logic                            out_free;
   logic                            in_grid;
   logic                            old_bit;
   logic                            new_bit;
   lgge_pkg::row_type               edit_row;

   // Handshake terms.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cell_out   = rsp_cell_ff;
   assign rsp_bus.generation = rsp_gen_ff;

   // A row whose valid flag is clear reads as all dead.
   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

   // Single-cell edit path on the row that was just read.
   assign in_grid  = (int'(col_ff) < lgge_pkg::GRID_WIDTH) &&
                     (int'(row_ff) < lgge_pkg::GRID_HEIGHT);
   assign old_bit  = rd_row[lgge_pkg::COL_IDX_W'(col_ff)];
   always_comb begin
      case (cmd_ff)
         lgge_pkg::CMD_WRITE:  new_bit = cell_in_ff;
         lgge_pkg::CMD_TOGGLE: new_bit = ~old_bit;
         default:              new_bit = old_bit;
      endcase
      edit_row = rd_row;
      edit_row[lgge_pkg::COL_IDX_W'(col_ff)] = new_bit;
   end

   // Sequencer and memory port control.
   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      row_valid_in = row_valid_ff;
      gen_in       = gen_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cell_in_in   = cell_in_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      pend_cell_in = pend_cell_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_gen_in   = rsp_gen_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;

      // The output register empties when its beat is taken.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in       = req_bus.command;
               col_in       = req_bus.col;
               row_in       = req_bus.row;
               cell_in_in   = req_bus.cell_in;
               pend_cell_in = 1'b0;
               unique case (req_bus.command) inside
                  lgge_pkg::CMD_CLEAR: begin
                     row_valid_in = '0;
                     gen_in       = '0;
                     state_in     = ST_FINISH;
                  end
                  lgge_pkg::CMD_WRITE, lgge_pkg::CMD_TOGGLE, lgge_pkg::CMD_READ: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = lgge_pkg::ROW_IDX_W'(req_bus.row);
                     state_in    = ST_CELL;
                  end
                  lgge_pkg::CMD_STEP: begin
                     // Fetch the last row first: it sits above row 0.
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = lgge_pkg::ROW_IDX_W'(lgge_pkg::GRID_HEIGHT - 1);
                     step_cnt_in = '0;
                     state_in    = ST_STEP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_CELL: begin
            if (in_grid && ((cmd_ff == lgge_pkg::CMD_WRITE) ||
                            (cmd_ff == lgge_pkg::CMD_TOGGLE))) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = lgge_pkg::ROW_IDX_W'(row_ff);
               mem_wr_data  = edit_row;
               row_valid_in[lgge_pkg::ROW_IDX_W'(row_ff)] = 1'b1;
            end
            pend_cell_in = in_grid && new_bit;
            state_in     = ST_FINISH;
         end

         ST_STEP: begin
            // Stream rows 0 to GRID_HEIGHT-1 out of the memory.
            if (step_cnt_ff < CNT_W'(lgge_pkg::GRID_HEIGHT)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = step_cnt_ff[lgge_pkg::ROW_IDX_W-1:0];
            end
            if (step_cnt_ff == '0) begin
               above_in = rd_row;
            end else if (step_cnt_ff == CNT_W'(1)) begin
               cur_in = rd_row;
               top_in = rd_row;
            end else begin
               // The arriving row is the one below the current row.
               mem_wr_en   = 1'b1;
               mem_wr_addr = lgge_pkg::ROW_IDX_W'(step_cnt_ff - CNT_W'(2));
               mem_wr_data = lgge_pkg::life_row(above_ff, cur_ff, rd_row);
               row_valid_in[lgge_pkg::ROW_IDX_W'(step_cnt_ff - CNT_W'(2))] = 1'b1;
               above_in    = cur_ff;
               cur_in      = rd_row;
            end
            if (step_cnt_ff == CNT_W'(lgge_pkg::GRID_HEIGHT)) begin
               state_in = ST_LAST;
            end else begin
               step_cnt_in = step_cnt_ff + CNT_W'(1);
            end
         end

         ST_LAST: begin
            // The last row wraps onto the saved old row 0.
            mem_wr_en   = 1'b1;
            mem_wr_addr = lgge_pkg::ROW_IDX_W'(lgge_pkg::GRID_HEIGHT - 1);
            mem_wr_data = lgge_pkg::life_row(above_ff, cur_ff, top_ff);
            row_valid_in[lgge_pkg::GRID_HEIGHT-1] = 1'b1;
            gen_in      = gen_ff + lgge_pkg::GEN_W'(1);
            state_in    = ST_FINISH;
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = pend_cell_ff;
               rsp_gen_in   = gen_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         row_valid_ff <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         row_valid_ff <= row_valid_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cell_in_ff   <= cell_in_in;
      above_ff     <= above_in;
      cur_ff       <= cur_in;
      top_ff       <= top_in;
      pend_cell_ff <= pend_cell_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_gen_ff   <= rsp_gen_in;
   end

   // Grid memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
         rd_vld_ff  <= row_valid_ff[mem_rd_addr];
      end
   end

   // The memory is written only while editing a cell or stepping.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == ST_CELL) || (state_ff == ST_STEP) ||
                     (state_ff == ST_LAST)))
      else $error("grid memory written outside an edit or a step");

   // The step counter never runs past the last row.
   assert property (@(posedge clock) disable iff (reset)
      step_cnt_ff <= CNT_W'(lgge_pkg::GRID_HEIGHT))
      else $error("step counter out of range");

   // Finishing a step advances the generation count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |=> (gen_ff == $past(gen_ff) + lgge_pkg::GEN_W'(1)))
      else $error("generation count did not advance after a step");

   // An accepted clear leaves every row invalid and the count at zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_bus.command == lgge_pkg::CMD_CLEAR)) |=>
         ((row_valid_ff == '0) && (gen_ff == '0)))
      else $error("clear did not empty the grid");

   // The result register is loaded only from the finish state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result beat raised outside the finish state");

endmodule

// ===== bench/lgge_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid checker
// Watches the command and result channels of the life grid engine, keeps its
// own copy of the grid and the generation count, and compares every result
// beat, field by field and in order, with the result it predicted.
// ----------------------------------------------------------------------------
module lgge_grid_checker
   import lgge_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lgge_req_if  req_mon,
   lgge_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   // Neighbor counts of the B3/S23 rule.
   localparam int BIRTH_COUNT = 3;
   localparam int SURVIVE_MIN = 2;

   typedef struct packed {
      logic             cell_bit;
      logic [GEN_W-1:0] gen;
   } cell_result_type;

   logic [GRID_WIDTH-1:0] grid_rows [GRID_HEIGHT];
   logic [GEN_W-1:0]      gen_count;
   cell_result_type       result_q [$];
   int                    error_total = 0;

   // Prints one line per mismatch and counts it.
   task automatic report_error(input string msg);
      error_total++;
      $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      logic [GRID_WIDTH-1:0] next_rows [GRID_HEIGHT];
      cell_result_type       want;
      int                    live;

      if (reset) begin
         for (int r = 0; r < GRID_HEIGHT; r++) grid_rows[r] = '0;
         gen_count = '0;
         result_q.delete();
      end else begin
         // A result beat is checked first: it always belongs to an earlier command.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_q.size() == 0) begin
               report_error($sformatf("result beat with nothing expected (cell %0d, gen %0d)",
                                      rsp_mon.cell_out, rsp_mon.generation));
            end else begin
               want = result_q.pop_front();
               if (rsp_mon.cell_out !== want.cell_bit)
                  report_error($sformatf("cell_out mismatch: expected %0d, got %0d",
                                         want.cell_bit, rsp_mon.cell_out));
               if (rsp_mon.generation !== want.gen)
                  report_error($sformatf("generation mismatch: expected %0d, got %0d",
                                         want.gen, rsp_mon.generation));
            end
         end

         // Apply an accepted command beat to the grid and queue its result.
         if (req_mon.valid && req_mon.ready) begin
            want.cell_bit = 1'b0;
            case (req_mon.command)
               CMD_CLEAR: begin
                  for (int r = 0; r < GRID_HEIGHT; r++) grid_rows[r] = '0;
                  gen_count = '0;
               end
               CMD_WRITE: begin
                  grid_rows[req_mon.row][req_mon.col] = req_mon.cell_in;
                  want.cell_bit = req_mon.cell_in;
               end
               CMD_TOGGLE: begin
                  grid_rows[req_mon.row][req_mon.col] = ~grid_rows[req_mon.row][req_mon.col];
                  want.cell_bit = grid_rows[req_mon.row][req_mon.col];
               end
               CMD_READ: begin
                  want.cell_bit = grid_rows[req_mon.row][req_mon.col];
               end
               CMD_STEP: begin
                  // Every cell looks at its eight neighbors, wrapping on all edges.
                  for (int r = 0; r < GRID_HEIGHT; r++) begin
                     for (int c = 0; c < GRID_WIDTH; c++) begin
                        live = 0;
                        for (int dr = -1; dr <= 1; dr++) begin
                           for (int dc = -1; dc <= 1; dc++) begin
                              if (dr != 0 || dc != 0)
                                 live += grid_rows[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                                                  [(c + dc + GRID_WIDTH) % GRID_WIDTH];
                           end
                        end
                        next_rows[r][c] = grid_rows[r][c] ?
                                          (live == SURVIVE_MIN || live == BIRTH_COUNT) :
                                          (live == BIRTH_COUNT);
                     end
                  end
                  grid_rows = next_rows;
                  gen_count = gen_count + 1'b1;
               end
               default: begin
                  // Undefined commands leave the grid and the count alone.
               end
            endcase
            want.gen = gen_count;
            result_q.push_back(want);
         end
      end

      fail_count    <= error_total;
      pending_count <= result_q.size();
   end

endmodule

// ===== bench/tb_life_grid_generation_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Drives directed and random command beats into the engine with random idle
// cycles on both channels. Random traffic seeds small live patterns at random
// places on the torus and then steps and probes them. The grid checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_engine_core;
   import lgge_pkg::*;

   // Command codes that the engine does not define.
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

   localparam int CMD_TARGET  = 1900;
   localparam int IDLE_PCT    = 28;
   localparam int SETTLE_CYC  = 50;

   logic clock;
   logic reset;
   bit   idle_enable;
   int   fail_count;
   int   pending_count;
   int   sent_total;

   lgge_req_if req_bus ();
   lgge_rsp_if rsp_bus ();

   life_grid_generation_engine_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   lgge_grid_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Hard limit on run time.
   initial begin
      #20_000_000;
      $display("tb_life_grid_generation_engine_core NOT OK");
      $finish;
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !idle_enable || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Sends one command beat, with random idle cycles ahead of it.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int col_idx,
                           input int row_idx, input logic cell_val);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.col     <= COL_W'(col_idx);
      req_bus.row     <= ROW_W'(row_idx);
      req_bus.cell_in <= cell_val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_total++;
   endtask

   // Holds off the command side until every expected result has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int base_col;
      int base_row;
      int span;
      int pick;

      reset           <= 1'b1;
      idle_enable     <= 1'b1;
      sent_total      = 0;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_CLEAR;
      req_bus.col     <= '0;
      req_bus.row     <= '0;
      req_bus.cell_in <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: grid state after reset, corner cells, toggling, undefined codes.
      send_cmd(CMD_READ, 0, 0, 1'b0);
      send_cmd(CMD_STEP, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
      send_cmd(CMD_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
      send_cmd(CMD_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b0);
      send_cmd(CMD_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b0);
      send_cmd(CMD_TOGGLE, 0, 0, 1'b1);
      send_cmd(CMD_TOGGLE, 0, 0, 1'b0);
      send_cmd(CMD_RSVD_FIRST, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
      send_cmd(CMD_RSVD_FIRST + 3'd1, 0, 0, 1'b0);
      send_cmd(CMD_RSVD_LAST, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);

      // A blinker lying across the left/right seam on row 0; it flips into a
      // vertical bar across the top/bottom seam and back.
      send_cmd(CMD_WRITE, GRID_WIDTH - 1, 0, 1'b1);
      send_cmd(CMD_WRITE, 0, 0, 1'b1);
      send_cmd(CMD_WRITE, 1, 0, 1'b1);
      send_cmd(CMD_STEP, 0, 0, 1'b0);
      send_cmd(CMD_READ, 0, GRID_HEIGHT - 1, 1'b0);
      send_cmd(CMD_READ, 0, 1, 1'b0);
      send_cmd(CMD_READ, GRID_WIDTH - 1, 0, 1'b0);
      send_cmd(CMD_STEP, 0, 0, 1'b0);
      send_cmd(CMD_READ, GRID_WIDTH - 1, 0, 1'b0);
      send_cmd(CMD_CLEAR, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
      send_cmd(CMD_READ, 0, 0, 1'b0);
      drain_results();

      // Random episodes: seed a small patch, then step it and probe around it.
      while (sent_total < CMD_TARGET) begin
         idle_enable <= !(sent_total >= 700 && sent_total < 1000);
         base_col = $urandom_range(0, GRID_WIDTH - 1);
         base_row = $urandom_range(0, GRID_HEIGHT - 1);
         span     = $urandom_range(3, 8);

         if ($urandom_range(0, 4) == 0)
            send_cmd(CMD_CLEAR, $urandom_range(0, GRID_WIDTH - 1),
                     $urandom_range(0, GRID_HEIGHT - 1), 1'($urandom_range(0, 1)));

         repeat ($urandom_range(5, 20)) begin
            send_cmd(CMD_WRITE, (base_col + $urandom_range(0, span - 1)) % GRID_WIDTH,
                     (base_row + $urandom_range(0, span - 1)) % GRID_HEIGHT,
                     $urandom_range(0, 5) != 0);
         end

         repeat ($urandom_range(2, 10)) begin
            send_cmd(CMD_STEP, $urandom_range(0, GRID_WIDTH - 1),
                     $urandom_range(0, GRID_HEIGHT - 1), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4)) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) begin
                  send_cmd(CMD_READ,
                           (base_col + $urandom_range(0, span + 1) + GRID_WIDTH - 1)
                              % GRID_WIDTH,
                           (base_row + $urandom_range(0, span + 1) + GRID_HEIGHT - 1)
                              % GRID_HEIGHT,
                           1'($urandom_range(0, 1)));
               end else if (pick < 8) begin
                  send_cmd(CMD_TOGGLE, (base_col + $urandom_range(0, span - 1)) % GRID_WIDTH,
                           (base_row + $urandom_range(0, span - 1)) % GRID_HEIGHT,
                           1'($urandom_range(0, 1)));
               end else if (pick == 8) begin
                  send_cmd(CMD_WRITE, $urandom_range(0, GRID_WIDTH - 1),
                           $urandom_range(0, GRID_HEIGHT - 1), 1'($urandom_range(0, 1)));
               end else begin
                  send_cmd(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
                           $urandom_range(0, GRID_WIDTH - 1),
                           $urandom_range(0, GRID_HEIGHT - 1), 1'($urandom_range(0, 1)));
               end
            end
         end

         if ($urandom_range(0, 9) == 0) drain_results();
      end

      // Let everything come back, then give the verdict.
      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_life_grid_generation_engine_core OK");
      end else begin
         $display("tb_life_grid_generation_engine_core NOT OK");
      end
      $finish;
   end

endmodule
